@@ rtl/size_class_block_allocator_macros.svh @@
// assertion helpers used by the allocator rtl
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define SCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// shared types and constants of the size class block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

	localparam int PAGE_BYTES_DEF  = 4096;
	localparam int HEAP_BYTES_DEF  = 1048576;
	localparam int NUM_CLASSES_DEF = 9;

	localparam int HDR_BYTES = 8;
	localparam int ADDR_W    = 20;
	localparam int SIZE_W    = 16;
	localparam int STATUS_W  = 3;
	localparam int CLASS_W   = 4;
	localparam int TAG_W     = CLASS_W + 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NULL     = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_OOM      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd4;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_POP,
		S_FREE,
		S_SWEEP,
		S_CARVE_END
	} state_t;

	typedef struct packed {
		logic link_we;
		logic tag_we;
	} mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/sca_slot_mem.sv @@
// ----------------------------------------------------------------------------
// sca_slot_mem
// per-slot link and header tag memories, one write and one registered read each
// ----------------------------------------------------------------------------
`default_nettype none

module sca_slot_mem #(
	parameter int SLOTS = sca_pkg::HEAP_BYTES_DEF / 8
) (
	input  wire logic                       clk,
	input  wire sca_pkg::mem_ctl_t          ctl,
	input  wire logic [$clog2(SLOTS)-1:0]   link_waddr,
	input  wire logic [$clog2(SLOTS)-1:0]   link_wdata,
	input  wire logic [$clog2(SLOTS)-1:0]   link_raddr,
	output logic      [$clog2(SLOTS)-1:0]   link_rdata,
	input  wire logic [$clog2(SLOTS)-1:0]   tag_waddr,
	input  wire logic [sca_pkg::TAG_W-1:0]  tag_wdata,
	input  wire logic [$clog2(SLOTS)-1:0]   tag_raddr,
	output logic      [sca_pkg::TAG_W-1:0]  tag_rdata
);
	import sca_pkg::*;

	localparam int SW = $clog2(SLOTS);

	logic [SW-1:0]    link_mem [SLOTS];
	logic [TAG_W-1:0] tag_mem  [SLOTS];

	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rdata <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		tag_rdata <= tag_mem[tag_raddr];
	end

endmodule

`default_nettype wire

@@ rtl/size_class_block_allocator.sv @@
// ----------------------------------------------------------------------------
// size_class_block_allocator
// segregated free-list allocator with power-of-two size classes
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all HEAP_BYTES/8 slots of
// the header tag memory with busy high. A request is taken when start is high
// and busy is low; its result appears on result_address, status and
// page_taken for exactly one cycle with done high and cannot be held off.
// Null requests, refused pages, page releases and malformed frees answer in
// the cycle after acceptance. A pop from a non-empty list or a valid free
// first reads the slot memory, then writes back. An allocation that refills
// its list, and a large allocation, sweeps every 8-byte slot of the page once,
// one slot at a time through the single write port of the tag memory; a
// refill then ends with one more step that hands out a block.
`default_nettype none

`include "size_class_block_allocator_macros.svh"

module size_class_block_allocator #(
	parameter int PAGE_BYTES  = sca_pkg::PAGE_BYTES_DEF,
	parameter int HEAP_BYTES  = sca_pkg::HEAP_BYTES_DEF,
	parameter int NUM_CLASSES = sca_pkg::NUM_CLASSES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          operation,
	input  wire logic [sca_pkg::SIZE_W-1:0]    request_size,
	input  wire logic [sca_pkg::ADDR_W-1:0]    free_address,
	input  wire logic                          page_available,
	input  wire logic [sca_pkg::ADDR_W-1:0]    page_address,
	output logic                               done,
	output logic      [sca_pkg::ADDR_W-1:0]    result_address,
	output logic      [sca_pkg::STATUS_W-1:0]  status,
	output logic                               page_taken
);
	import sca_pkg::*;

	localparam int SLOTS     = HEAP_BYTES / 8;
	localparam int SW        = $clog2(SLOTS);
	localparam int PS        = PAGE_BYTES / 8;
	localparam int PW        = $clog2(PS);
	localparam int CI_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int MAX_CLASS = 8 << (NUM_CLASSES - 1);

	state_t state_q, state_d;

	// input decode
	logic [CI_W-1:0] cls_c;
	logic [16:0]     stride_c;
	logic            fits_c;
	logic [19:0]     pg_c;
	logic [24:0]     pg_end_c;
	logic            page_ok_c;
	logic [21:0]     fa_m8_c;
	logic [21:0]     fslot_c;
	logic            fa_bad_c;

	// latched request
	logic [CI_W-1:0] c_q;
	logic [SW-1:0]   slot_q;
	logic [SW-1:0]   base_q;
	logic [19:0]     pg_q;
	logic            large_q;
	logic [16:0]     stride_q;

	// list heads
	logic            head_vld_q [NUM_CLASSES];
	logic [SW-1:0]   head_idx_q [NUM_CLASSES];
	logic            head_we;
	logic [CI_W-1:0] head_sel;
	logic            head_vld_d;
	logic [SW-1:0]   head_idx_d;

	// page sweep
	logic [PW-1:0]   k_q;
	logic [16:0]     next_start_q;
	logic            have_prev_q, have_prev2_q;
	logic [SW-1:0]   prev_q, prev2_q;
	logic [SW-1:0]   sweep_addr;
	logic            carve_c;
	logic            last_k;
	logic [SW-1:0]   clr_q;

	// memory
	mem_ctl_t        mem_ctl;
	logic [SW-1:0]   link_waddr, link_wdata, link_rdata;
	logic [SW-1:0]   tag_waddr;
	logic [TAG_W-1:0] tag_wdata, tag_rdata;
	logic [CLASS_W-1:0] tag_cls;
	logic            tag_ok;
	logic [CI_W-1:0] tsel;

	// result
	logic                out_load;
	logic [ADDR_W-1:0]   out_res_d;
	logic [STATUS_W-1:0] out_stat_d;
	logic                out_taken_d;
	logic                done_q;
	logic [ADDR_W-1:0]   res_q;
	logic [STATUS_W-1:0] stat_q;
	logic                taken_q;

	always_comb begin
		cls_c = CI_W'(NUM_CLASSES - 1);
		for (int i = NUM_CLASSES - 2; i >= 0; i--) begin
			if (17'(request_size) <= 17'(8 << i)) begin
				cls_c = CI_W'(i);
			end
		end
	end

	assign stride_c  = (17'd1 << cls_c) + 17'd1;
	assign fits_c    = stride_c <= 17'(PS);
	assign pg_c      = page_address & ~20'(PAGE_BYTES - 1);
	assign pg_end_c  = 25'(pg_c) + 25'(PAGE_BYTES);
	assign page_ok_c = page_available && (pg_c != 20'd0) && (pg_end_c <= 25'(HEAP_BYTES))
		&& (pg_end_c <= 25'(1 << ADDR_W));
	assign fa_m8_c   = 22'(free_address) - 22'(HDR_BYTES);
	assign fslot_c   = fa_m8_c >> 3;
	assign fa_bad_c  = (free_address[2:0] != 3'd0) || (free_address < 20'(HDR_BYTES))
		|| (fslot_c >= 22'(SLOTS));

	assign tag_cls = tag_rdata[CLASS_W-1:0];
	assign tag_ok  = tag_rdata[TAG_W-1] && (tag_cls < CLASS_W'(NUM_CLASSES));
	assign tsel    = CI_W'(tag_cls);

	assign sweep_addr = base_q + SW'(k_q);
	assign carve_c    = !large_q && (17'(k_q) == next_start_q)
		&& ((next_start_q + stride_q) <= 17'(PS));
	assign last_k     = k_q == PW'(PS - 1);

	always_comb begin
		state_d     = state_q;
		mem_ctl     = '0;
		link_waddr  = slot_q;
		link_wdata  = '0;
		tag_waddr   = slot_q;
		tag_wdata   = '0;
		head_we     = 1'b0;
		head_sel    = c_q;
		head_vld_d  = 1'b0;
		head_idx_d  = slot_q;
		out_load    = 1'b0;
		out_res_d   = '0;
		out_stat_d  = STAT_OK;
		out_taken_d = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_ctl.tag_we = 1'b1;
				tag_waddr      = clr_q;
				if (clr_q == SW'(SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (operation == OP_ALLOC) begin
						if (request_size == '0) begin
							out_load   = 1'b1;
							out_stat_d = STAT_NULL;
						end else if (17'(request_size) > 17'(MAX_CLASS)) begin
							if (page_ok_c) begin
								state_d = S_SWEEP;
							end else begin
								out_load   = 1'b1;
								out_stat_d = STAT_OOM;
							end
						end else if (head_vld_q[cls_c]) begin
							state_d = S_POP;
						end else if (page_ok_c && fits_c) begin
							state_d = S_SWEEP;
						end else begin
							out_load   = 1'b1;
							out_stat_d = STAT_OOM;
						end
					end else begin
						if (free_address == '0) begin
							out_load   = 1'b1;
							out_stat_d = STAT_NULL;
						end else if ((free_address & 20'(PAGE_BYTES - 1)) == 20'd0) begin
							out_load   = 1'b1;
							out_stat_d = STAT_RELEASED;
						end else if (fa_bad_c) begin
							out_load   = 1'b1;
							out_stat_d = STAT_IGNORED;
						end else begin
							state_d = S_FREE;
						end
					end
				end
			end
			S_POP: begin
				mem_ctl.tag_we = 1'b1;
				tag_wdata      = {1'b1, CLASS_W'(c_q)};
				head_we        = 1'b1;
				head_vld_d     = link_rdata != '0;
				head_idx_d     = link_rdata;
				out_load       = 1'b1;
				out_res_d      = ADDR_W'({slot_q, 3'b000} + (SW + 3)'(HDR_BYTES));
				state_d        = S_IDLE;
			end
			S_FREE: begin
				out_load = 1'b1;
				if (tag_ok) begin
					mem_ctl.tag_we  = 1'b1;
					mem_ctl.link_we = 1'b1;
					link_wdata      = head_vld_q[tsel] ? head_idx_q[tsel] : '0;
					head_we         = 1'b1;
					head_sel        = tsel;
					head_vld_d      = 1'b1;
				end else begin
					out_stat_d = STAT_IGNORED;
				end
				state_d = S_IDLE;
			end
			S_SWEEP: begin
				mem_ctl.tag_we = 1'b1;
				tag_waddr      = sweep_addr;
				link_waddr     = sweep_addr;
				if (carve_c) begin
					// blocks chain toward lower offsets, first one ends the list
					mem_ctl.link_we = 1'b1;
					link_wdata      = have_prev_q ? prev_q : '0;
				end
				if (last_k) begin
					if (large_q) begin
						out_load    = 1'b1;
						out_res_d   = pg_q;
						out_taken_d = 1'b1;
						state_d     = S_IDLE;
					end else begin
						state_d = S_CARVE_END;
					end
				end
			end
			S_CARVE_END: begin
				// hand out the highest block, the one below it becomes head
				mem_ctl.tag_we = 1'b1;
				tag_waddr      = prev_q;
				tag_wdata      = {1'b1, CLASS_W'(c_q)};
				head_we        = 1'b1;
				head_vld_d     = have_prev2_q;
				head_idx_d     = prev2_q;
				out_load       = 1'b1;
				out_res_d      = ADDR_W'({prev_q, 3'b000} + (SW + 3)'(HDR_BYTES));
				out_taken_d    = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			done_q       <= 1'b0;
			k_q          <= '0;
			next_start_q <= '0;
			have_prev_q  <= 1'b0;
			have_prev2_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_vld_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= out_load;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (head_we) begin
				head_vld_q[head_sel] <= head_vld_d;
			end
			if (state_q == S_IDLE) begin
				k_q          <= '0;
				next_start_q <= '0;
				have_prev_q  <= 1'b0;
				have_prev2_q <= 1'b0;
			end else if (state_q == S_SWEEP) begin
				k_q <= k_q + PW'(1);
				if (carve_c) begin
					next_start_q <= next_start_q + stride_q;
					have_prev_q  <= 1'b1;
					have_prev2_q <= have_prev_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			c_q      <= cls_c;
			slot_q   <= (operation == OP_FREE) ? fslot_c[SW-1:0] : head_idx_q[cls_c];
			base_q   <= SW'(pg_c >> 3);
			pg_q     <= pg_c;
			large_q  <= 17'(request_size) > 17'(MAX_CLASS);
			stride_q <= stride_c;
		end
		if (state_q == S_SWEEP && carve_c) begin
			prev_q  <= sweep_addr;
			prev2_q <= prev_q;
		end
		if (head_we) begin
			head_idx_q[head_sel] <= head_idx_d;
		end
		if (out_load) begin
			res_q   <= out_res_d;
			stat_q  <= out_stat_d;
			taken_q <= out_taken_d;
		end
	end

	sca_slot_mem #(
		.SLOTS(SLOTS)
	) u_slot_mem (
		.clk        (clk),
		.ctl        (mem_ctl),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_raddr (head_idx_q[cls_c]),
		.link_rdata (link_rdata),
		.tag_waddr  (tag_waddr),
		.tag_wdata  (tag_wdata),
		.tag_raddr  (fslot_c[SW-1:0]),
		.tag_rdata  (tag_rdata)
	);

	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign result_address = res_q;
	assign status         = stat_q;
	assign page_taken     = taken_q;

	`SCA_ASSERT_NOW(a_no_result_in_clear, state_q == S_CLEAR, !done_q, "result during clearing pass")
	`SCA_ASSERT_NOW(a_fail_has_no_addr, done_q && stat_q != STAT_OK, res_q == '0 && !taken_q, "failed transaction carries an address")
	`SCA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_q, "accepted transaction neither working nor answered")
	`SCA_ASSERT_NOW(a_sweep_page_ok, state_q == S_SWEEP, base_q != '0, "sweep over page zero")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the size class block allocator: a directed pass
// over the corner cases, then random allocate/free traffic, compared against
// a behavioral model of the class free lists and header tags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import sca_pkg::*;

	localparam int PAGE_B  = PAGE_BYTES_DEF;
	localparam int HEAP_B  = HEAP_BYTES_DEF;
	localparam int CLASSES = NUM_CLASSES_DEF;
	localparam int SLOTS   = HEAP_B / 8;
	localparam int TAG_VLD = 16;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] stat;
		logic                taken;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic operation = OP_ALLOC;
	logic [SIZE_W-1:0] request_size = '0;
	logic [ADDR_W-1:0] free_address = '0;
	logic page_available = 1'b0;
	logic [ADDR_W-1:0] page_address = '0;
	logic busy, done, page_taken;
	logic [ADDR_W-1:0] result_address;
	logic [STATUS_W-1:0] status;

	size_class_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .request_size(request_size),
		.free_address(free_address), .page_available(page_available),
		.page_address(page_address), .done(done),
		.result_address(result_address), .status(status), .page_taken(page_taken)
	);

	always #1 clk = ~clk;

	// model state of the free lists
	logic        list_valid [CLASSES];
	logic [16:0] list_head  [CLASSES];
	logic [16:0] next_slot  [SLOTS];
	logic [4:0]  header_tag [SLOTS];

	alloc_result_t pending_results[$];
	logic [ADDR_W-1:0] live_blocks[$];
	int errors = 0;
	int checked = 0;
	int sent = 0;
	int idle_pct = 0;

	// all lists empty, all header tags invalid
	function automatic void reset_model();
		for (int i = 0; i < CLASSES; i++)
			list_valid[i] = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			header_tag[i] = '0;
	endfunction

	function automatic void push_free(int c, logic [16:0] s);
		next_slot[s] = list_valid[c] ? list_head[c] : 17'd0;
		list_head[c] = s;
		list_valid[c] = 1'b1;
	endfunction

	function automatic void wipe_page_tags(logic [ADDR_W-1:0] pg);
		for (int k = 0; k < PAGE_B / 8; k++)
			header_tag[(pg >> 3) + k] = '0;
	endfunction

	function automatic alloc_result_t allocator_outcome(logic op, logic [SIZE_W-1:0] sz,
			logic [ADDR_W-1:0] fa, logic pav, logic [ADDR_W-1:0] pa);
		alloc_result_t r;
		logic [ADDR_W-1:0] pg;
		logic ok;
		int c, bs;
		logic [16:0] s;
		r = '{addr: '0, stat: STAT_OK, taken: 1'b0};
		pg = pa - (pa % PAGE_B);
		ok = pav && pg != 0 && (int'(pg) + PAGE_B <= HEAP_B)
			&& (int'(pg) + PAGE_B <= (1 << ADDR_W));
		if (op == OP_ALLOC) begin
			if (sz == 0) begin
				r.stat = STAT_NULL;
			end else if (sz > (8 << (CLASSES - 1))) begin
				if (ok) begin
					wipe_page_tags(pg);
					r.addr = pg;
					r.taken = 1'b1;
				end else begin
					r.stat = STAT_OOM;
				end
			end else begin
				c = 0;
				while (c + 1 < CLASSES && (8 << c) < sz)
					c++;
				if (!list_valid[c]) begin
					bs = (8 << c) + HDR_BYTES;
					if (!ok || bs > PAGE_B) begin
						r.stat = STAT_OOM;
					end else begin
						wipe_page_tags(pg);
						for (int j = 0; j + bs <= PAGE_B; j += bs)
							push_free(c, 17'((int'(pg) + j) >> 3));
						r.taken = 1'b1;
					end
				end
				if (r.stat == STAT_OK) begin
					s = list_head[c];
					header_tag[s] = 5'(TAG_VLD | c);
					list_valid[c] = next_slot[s] != 0;
					list_head[c] = next_slot[s];
					r.addr = ADDR_W'(int'(s) * 8 + HDR_BYTES);
					live_blocks.push_back(r.addr);
				end
			end
		end else begin
			if (fa == 0) begin
				r.stat = STAT_NULL;
			end else if (fa % PAGE_B == 0) begin
				r.stat = STAT_RELEASED;
			end else if (fa[2:0] != 0 || fa < HDR_BYTES
					|| ((int'(fa) - HDR_BYTES) >> 3) >= SLOTS) begin
				r.stat = STAT_IGNORED;
			end else begin
				s = 17'((fa - HDR_BYTES) >> 3);
				if (!header_tag[s][4] || header_tag[s][3:0] >= CLASSES) begin
					r.stat = STAT_IGNORED;
				end else begin
					c = header_tag[s][3:0];
					header_tag[s] = '0;
					push_free(c, s);
				end
			end
		end
		return r;
	endfunction

	// one transaction: drive at the current rising edge, hold until accepted
	task automatic issue(logic op, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] fa,
			logic pav, logic [ADDR_W-1:0] pa);
		start <= 1'b1;
		operation <= op;
		request_size <= sz;
		free_address <= fa;
		page_available <= pav;
		page_address <= pa;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(allocator_outcome(op, sz, fa, pav, pa));
		sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PAGE_B / 8 + 8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		alloc_result_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result addr=%h status=%0d", result_address, status);
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (result_address !== want.addr || status !== want.stat
						|| page_taken !== want.taken) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected addr=%h status=%0d taken=%0d, %s",
							want.addr, want.stat, want.taken,
							$sformatf("got addr=%h status=%0d taken=%0d",
								result_address, status, page_taken));
				end
			end
		end
	end

	function automatic logic [ADDR_W-1:0] any_page();
		return ADDR_W'(($urandom_range(1, 255) << 12) | $urandom_range(0, PAGE_B - 1));
	endfunction

	task automatic test_corner_cases();
		logic [ADDR_W-1:0] a;
		issue(OP_ALLOC, 16'd0, 20'hFFFFF, 1'b1, 20'h05000);
		issue(OP_ALLOC, 16'd1, '0, 1'b0, 20'h05000);
		issue(OP_ALLOC, 16'd1, '0, 1'b1, 20'h00FFF);
		issue(OP_ALLOC, 16'd1, '0, 1'b1, 20'h01ABC);
		issue(OP_ALLOC, 16'd8, '0, 1'b0, '0);
		issue(OP_ALLOC, 16'd2048, '0, 1'b1, 20'hFFFFF);
		issue(OP_ALLOC, 16'd2049, '0, 1'b0, 20'h02000);
		issue(OP_ALLOC, 16'hFFFF, '0, 1'b1, 20'h02000);
		issue(OP_ALLOC, 16'd3000, '0, 1'b1, 20'h00000);
		issue(OP_FREE, 16'hFFFF, 20'd0, 1'b1, 20'h03000);
		issue(OP_FREE, '0, 20'h03000, 1'b0, '0);
		issue(OP_FREE, '0, 20'h01003, 1'b0, '0);
		issue(OP_FREE, '0, 20'd4, 1'b0, '0);
		issue(OP_FREE, '0, 20'hFFFF8, 1'b0, '0);
		a = live_blocks[0];
		issue(OP_FREE, '0, a, 1'b0, '0);
		issue(OP_FREE, '0, a, 1'b0, '0);
		issue(OP_ALLOC, 16'd3, '0, 1'b0, '0);
		issue(OP_ALLOC, 16'd700, '0, 1'b1, 20'h07123);
		issue(OP_ALLOC, 16'd129, '0, 1'b1, 20'h08000);
		drain();
	endtask

	task automatic test_random_traffic(int n);
		int r, k;
		logic [ADDR_W-1:0] a;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				issue(OP_ALLOC, SIZE_W'($urandom_range(1, 8 << $urandom_range(0, 8))),
					ADDR_W'($urandom), $urandom_range(0, 9) != 0,
					$urandom_range(0, 19) == 0 ? ADDR_W'($urandom) : any_page());
			end else if (r < 63) begin
				issue(OP_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom), 1'($urandom),
					any_page());
			end else if (r < 90 && live_blocks.size() != 0) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				a = live_blocks[k];
				if ($urandom_range(0, 9) != 0)
					live_blocks.delete(k);
				issue(OP_FREE, SIZE_W'($urandom), a, 1'($urandom), ADDR_W'($urandom));
			end else begin
				issue(OP_FREE, SIZE_W'($urandom), ADDR_W'($urandom), 1'($urandom),
					ADDR_W'($urandom));
			end
		end
		drain();
	endtask

	initial begin
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 7;
		test_corner_cases();
		test_random_traffic(260);
		idle_pct = 78;
		test_random_traffic(260);
		idle_pct = 0;
		test_random_traffic(260);
		$display("covered %0d transactions, %0d results checked: corner cases, refills,",
			sent, checked);
		$display("page takes and releases, double and malformed frees under varied idling");
		if (errors == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
